>>> rtl/les_pkg.sv
// shared types, command codes and pattern tables for the lamp effect sequencer
package les_pkg;

   // command codes carried in one request beat
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_EDGE  = 2'd3
   } cmd_type;

   // configuration register indexes
   localparam logic CSR_HIGH_BEAM = 1'b0;
   localparam logic CSR_DEBOUNCE  = 1'b1;

   localparam int unsigned CSR_DATA_W = 16;

   // one request beat
   typedef struct packed {
      cmd_type            cmd;
      logic [3:0]         effect_id;
      logic signed [8:0]  repeat_count;
      logic [15:0]        step_delay;
      logic               beam_level;
   } beat_type;

   // one response beat
   typedef struct packed {
      logic [3:0] lamps;
      logic       lamps_written;
      logic       effect_active;
      logic       beam_active;
   } result_type;

   // number of steps in each pattern
   function automatic logic [3:0] pattern_len(input logic [2:0] eff);
      logic [3:0] len;
      case (eff)
         3'd0:    len = 4'd4;
         3'd1:    len = 4'd4;
         3'd2:    len = 4'd7;
         3'd3:    len = 4'd2;
         3'd4:    len = 4'd2;
         3'd5:    len = 4'd2;
         3'd6:    len = 4'd4;
         3'd7:    len = 4'd4;
         default: len = 4'd4;
      endcase
      return len;
   endfunction

   // lamp pattern of one step; steps past the end read as all off
   function automatic logic [3:0] pattern_step(input logic [2:0] eff, input logic [2:0] idx);
      logic [3:0] pat;
      pat = 4'b0000;
      case (eff)
         3'd0: begin
            case (idx)
               3'd0:    pat = 4'b1000;
               3'd1:    pat = 4'b0100;
               3'd2:    pat = 4'b0010;
               3'd3:    pat = 4'b0001;
               default: pat = 4'b0000;
            endcase
         end
         3'd1: begin
            case (idx)
               3'd0:    pat = 4'b0001;
               3'd1:    pat = 4'b0010;
               3'd2:    pat = 4'b0100;
               3'd3:    pat = 4'b1000;
               default: pat = 4'b0000;
            endcase
         end
         3'd2: begin
            case (idx)
               3'd0:    pat = 4'b0001;
               3'd1:    pat = 4'b0010;
               3'd2:    pat = 4'b0100;
               3'd3:    pat = 4'b1000;
               3'd4:    pat = 4'b0100;
               3'd5:    pat = 4'b0010;
               3'd6:    pat = 4'b0001;
               default: pat = 4'b0000;
            endcase
         end
         3'd3: begin
            case (idx)
               3'd0:    pat = 4'b1010;
               3'd1:    pat = 4'b0101;
               default: pat = 4'b0000;
            endcase
         end
         3'd4: begin
            case (idx)
               3'd0:    pat = 4'b1111;
               default: pat = 4'b0000;
            endcase
         end
         3'd5: begin
            case (idx)
               3'd0:    pat = 4'b1001;
               3'd1:    pat = 4'b0110;
               default: pat = 4'b0000;
            endcase
         end
         3'd6: begin
            case (idx)
               3'd0:    pat = 4'b1000;
               3'd1:    pat = 4'b1100;
               3'd2:    pat = 4'b1110;
               3'd3:    pat = 4'b1111;
               default: pat = 4'b0000;
            endcase
         end
         3'd7: begin
            case (idx)
               3'd0:    pat = 4'b0001;
               3'd1:    pat = 4'b0011;
               3'd2:    pat = 4'b0111;
               3'd3:    pat = 4'b1111;
               default: pat = 4'b0000;
            endcase
         end
         default: pat = 4'b0000;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/les_core.sv
// sequencer state, debounce counters and per-beat next-state logic
module les_core #(
   parameter int unsigned NUM_EFFECTS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [les_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                          fire,
   input  les_pkg::beat_type             beat,
   output les_pkg::result_type           result
);

   localparam logic [3:0] NUM_EFF_W = 4'(NUM_EFFECTS);

   // configuration
   logic [3:0]  high_beam_ff;
   logic [15:0] debounce_ff;

   // sequencer state
   logic [3:0]  lamp_ff,      lamp_in;
   logic        running_ff,   running_in;
   logic        stop_ff,      stop_in;
   logic        beam_sig_ff,  beam_sig_in;
   logic        beam_shown_ff, beam_shown_in;
   logic        first_ff,     first_in;
   logic [3:0]  effect_ff,    effect_in;
   logic [2:0]  step_ff,      step_in;
   logic [8:0]  repeats_ff,   repeats_in;
   logic [15:0] hold_ff,      hold_in;
   logic [15:0] elapsed_ff,   elapsed_in;
   logic [15:0] since_ff,     since_in;
   logic        wrote;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         high_beam_ff <= 4'd15;
         debounce_ff  <= 16'd50;
      end else if (csr_wr_en) begin
         case (csr_index)
            les_pkg::CSR_HIGH_BEAM: high_beam_ff <= csr_wr_data[3:0];
            les_pkg::CSR_DEBOUNCE:  debounce_ff  <= csr_wr_data[15:0];
            default:                ;
         endcase
      end
   end

   // next state for one beat
   always_comb begin
      logic [2:0]  eff;
      logic [2:0]  idx;
      logic [3:0]  idx_nxt;
      logic [15:0] elapsed_v;

      lamp_in       = lamp_ff;
      running_in    = running_ff;
      stop_in       = stop_ff;
      beam_sig_in   = beam_sig_ff;
      beam_shown_in = beam_shown_ff;
      first_in      = first_ff;
      effect_in     = effect_ff;
      step_in       = step_ff;
      repeats_in    = repeats_ff;
      hold_in       = hold_ff;
      elapsed_in    = elapsed_ff;
      since_in      = since_ff;
      wrote         = 1'b0;
      eff           = effect_ff[2:0];
      idx           = step_ff;
      idx_nxt       = 4'd0;
      elapsed_v     = elapsed_ff;

      case (beat.cmd)
         les_pkg::CMD_TICK: begin
            if (since_ff != 16'hFFFF) since_in = since_ff + 16'd1;
            // beam takes over, beam released, pending stop, then the pattern
            if (beam_sig_ff && !beam_shown_ff) begin
               lamp_in       = high_beam_ff;
               wrote         = 1'b1;
               beam_shown_in = 1'b1;
            end else if (!beam_sig_ff && beam_shown_ff) begin
               stop_in = 1'b1;
            end else if (stop_ff) begin
               lamp_in       = beam_sig_ff ? high_beam_ff : 4'd0;
               wrote         = 1'b1;
               beam_shown_in = beam_sig_ff;
               running_in    = 1'b0;
               stop_in       = 1'b0;
            end else if (running_ff) begin
               if (effect_ff >= NUM_EFF_W) begin
                  running_in = 1'b0;
                  lamp_in    = 4'd0;
                  wrote      = 1'b1;
               end else begin
                  // first step shows step zero
                  if (first_ff) begin
                     first_in = 1'b0;
                     lamp_in  = les_pkg::pattern_step(eff, 3'd0);
                     wrote    = 1'b1;
                     idx      = 3'd1;
                  end
                  step_in = idx;
                  // step due: finish or advance
                  if (elapsed_ff >= hold_ff) begin
                     if (repeats_ff == 9'd0) begin
                        running_in = 1'b0;
                        lamp_in    = 4'd0;
                        wrote      = 1'b1;
                     end else begin
                        elapsed_v = 16'd0;
                        lamp_in   = les_pkg::pattern_step(eff, idx);
                        wrote     = 1'b1;
                        idx_nxt   = {1'b0, idx} + 4'd1;
                        if (idx_nxt >= les_pkg::pattern_len(eff)) begin
                           step_in = 3'd0;
                           if (!repeats_ff[8]) repeats_in = repeats_ff - 9'd1;
                        end else begin
                           step_in = idx_nxt[2:0];
                        end
                     end
                  end
               end
            end
            if (elapsed_v != 16'hFFFF) elapsed_in = elapsed_v + 16'd1;
            else                       elapsed_in = elapsed_v;
         end
         les_pkg::CMD_START: begin
            stop_in    = 1'b0;
            lamp_in    = 4'd0;
            wrote      = 1'b1;
            first_in   = 1'b1;
            step_in    = 3'd0;
            repeats_in = beat.repeat_count;
            running_in = 1'b1;
            elapsed_in = 16'd0;
            hold_in    = beat.step_delay;
            effect_in  = beat.effect_id;
         end
         les_pkg::CMD_STOP: begin
            stop_in = 1'b1;
         end
         les_pkg::CMD_EDGE: begin
            // debounced beam edge
            if (since_ff > debounce_ff) begin
               if (beat.beam_level) stop_in = 1'b1;
               beam_sig_in = beat.beam_level;
               since_in    = 16'd0;
            end
         end
         default: ;
      endcase
   end

   assign result.lamps         = lamp_in;
   assign result.lamps_written = wrote;
   assign result.effect_active = running_in;
   assign result.beam_active   = beam_shown_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_ff       <= 4'd0;
         running_ff    <= 1'b0;
         stop_ff       <= 1'b0;
         beam_sig_ff   <= 1'b0;
         beam_shown_ff <= 1'b0;
         first_ff      <= 1'b0;
         effect_ff     <= 4'd0;
         step_ff       <= 3'd0;
         repeats_ff    <= 9'd0;
         hold_ff       <= 16'd0;
         elapsed_ff    <= 16'd0;
         since_ff      <= 16'hFFFF;
      end else if (fire) begin
         lamp_ff       <= lamp_in;
         running_ff    <= running_in;
         stop_ff       <= stop_in;
         beam_sig_ff   <= beam_sig_in;
         beam_shown_ff <= beam_shown_in;
         first_ff      <= first_in;
         effect_ff     <= effect_in;
         step_ff       <= step_in;
         repeats_ff    <= repeats_in;
         hold_ff       <= hold_in;
         elapsed_ff    <= elapsed_in;
         since_ff      <= since_in;
      end
   end

endmodule

>>> rtl/lamp_effect_sequencer.sv
// top level: request register, sequencer core and response register
//
//  channel  | ports                                            | direction
//  ---------+--------------------------------------------------+----------
//  request  | req_valid req_ready req_cmd .. req_beam_level    | in
//  response | rsp_valid rsp_ready rsp_lamps .. rsp_beam_active | out
//  csr      | csr_wr_en csr_index csr_wr_data                  | in
//
// one beat per cycle sustained while rsp_ready holds; an accepted request passes
// through the request register, then the state update into the response
// register, where it raises rsp_valid.
// synchronous active-high reset returns all sequencer state and the csrs to defaults.
// a stalled response holds the pipe; the request register still takes a beat
// while empty, so a full response and a waiting request can sit side by side.
module lamp_effect_sequencer #(
   parameter int unsigned NUM_EFFECTS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_cmd,
   input  logic [3:0]                     req_effect_id,
   input  logic signed [8:0]              req_repeat_count,
   input  logic [15:0]                    req_step_delay,
   input  logic                           req_beam_level,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [3:0]                     rsp_lamps,
   output logic                           rsp_lamps_written,
   output logic                           rsp_effect_active,
   output logic                           rsp_beam_active,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [les_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   logic                 in_vld_ff;
   les_pkg::beat_type    in_beat_ff;
   logic                 out_vld_ff;
   les_pkg::result_type  out_ff;
   les_pkg::result_type  result;
   logic                 advance;
   logic                 fire;

   // pipe moves when the response register is free or being drained
   assign advance   = !out_vld_ff || rsp_ready;
   assign fire      = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_beat_ff.cmd          <= les_pkg::cmd_type'(req_cmd);
         in_beat_ff.effect_id    <= req_effect_id;
         in_beat_ff.repeat_count <= req_repeat_count;
         in_beat_ff.step_delay   <= req_step_delay;
         in_beat_ff.beam_level   <= req_beam_level;
      end
   end

   les_core #(
      .NUM_EFFECTS (NUM_EFFECTS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .beat        (in_beat_ff),
      .result      (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_lamps         = out_ff.lamps;
   assign rsp_lamps_written = out_ff.lamps_written;
   assign rsp_effect_active = out_ff.effect_active;
   assign rsp_beam_active   = out_ff.beam_active;

endmodule
